@@ rtl/swseg_pkg.sv @@
package swseg_pkg;

    localparam int DIGIT_COUNT = 8;
    localparam int CODE_W      = 5;
    localparam int IDX_W       = $clog2(DIGIT_COUNT);
    localparam int BCD_DIGITS  = 5;
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int SW_W        = 16;

    // Button codes that select a display mode
    localparam logic [4:0] BTN_BINARY  = 5'h01;
    localparam logic [4:0] BTN_HEX     = 5'h02;
    localparam logic [4:0] BTN_DECIMAL = 5'h10;

    localparam logic [CODE_W-1:0] BLANK_CODE = 5'd16;
    localparam logic [7:0]        SEG_BLANK  = 8'hff;

    // Active-low segment patterns for codes 0..15 and blank
    localparam logic [7:0] SEG_TABLE [0:16] = '{
        8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90,
        8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e, 8'hff
    };

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             load;       // capture a new input item
        logic             dab_step;   // one double-dabble step
        logic             dab_store;  // write decimal digits to the codes
        logic [IDX_W-1:0] scan_idx;   // digit being shown
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic dec_mode;               // offered item selects decimal mode
    } status_t;

    function automatic logic [7:0] seg_of(input logic [CODE_W-1:0] code);
        logic [7:0] seg;
        if (code > BLANK_CODE) begin
            seg = SEG_BLANK;
        end else begin
            seg = SEG_TABLE[code];
        end
        return seg;
    endfunction

endpackage

@@ rtl/swseg_ctrl.sv @@
module swseg_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  swseg_pkg::status_t status,
    output swseg_pkg::cmd_t    cmd
);
    import swseg_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CONV  = 2'd1;
    localparam logic [1:0] ST_STORE = 2'd2;
    localparam logic [1:0] ST_SCAN  = 2'd3;

    localparam logic [3:0] CONV_LAST = 4'(SW_W - 1);
    localparam logic [3:0] SCAN_LAST = 4'(DIGIT_COUNT - 1);

    logic [1:0] state_reg, state_next;
    logic [3:0] count_reg, count_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_SCAN);

    // Decode commands from the state
    always_comb begin
        cmd.load      = s_ready && s_valid;
        cmd.dab_step  = (state_reg == ST_CONV);
        cmd.dab_store = (state_reg == ST_STORE);
        cmd.scan_idx  = count_reg[IDX_W-1:0];
    end

    // Advance through convert, store and scan
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = status.dec_mode ? ST_CONV : ST_SCAN;
                    count_next = 4'd0;
                end
            end
            ST_CONV: begin
                count_next = count_reg + 4'd1;
                if (count_reg == CONV_LAST) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                state_next = ST_SCAN;
                count_next = 4'd0;
            end
            ST_SCAN: begin
                if (m_ready) begin
                    count_next = count_reg + 4'd1;
                    if (count_reg == SCAN_LAST) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= 4'd0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Input and result sides never open together
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is offered");

    // A stalled result keeps its digit
    a_hold_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(cmd.scan_idx)))
        else $error("scan digit moved under stall");

    // The last digit taken frees the input side
    a_end_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && (count_reg == SCAN_LAST)) |=> s_ready)
        else $error("block not idle after the final digit");

    // A decimal item converts before any result appears
    a_dec_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && status.dec_mode) |=> (cmd.dab_step && !m_valid))
        else $error("decimal item skipped conversion");

endmodule

@@ rtl/swseg_dp.sv @@
module swseg_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [4:0]                    s_buttons,
    input  logic [swseg_pkg::SW_W-1:0]    s_switches,
    input  swseg_pkg::cmd_t               cmd,
    output swseg_pkg::status_t            status,
    output logic [7:0]                    m_digit_select,
    output logic [7:0]                    m_segments,
    output logic                          m_last_digit
);
    import swseg_pkg::*;

    logic [CODE_W-1:0] codes_reg [DIGIT_COUNT];
    logic [BCD_W-1:0]  bcd_reg;
    logic [SW_W-1:0]   bin_reg;
    logic [BCD_W-1:0]  bcd_adj;

    assign status.dec_mode = (s_buttons == BTN_DECIMAL);

    // Add three to every BCD digit of five or more before the shift
    always_comb begin
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (bcd_reg[4*d +: 4] >= 4'd5) begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end else begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
    end

    // Shift the binary value into the BCD register
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            bin_reg <= s_switches;
            bcd_reg <= '0;
        end else if (cmd.dab_step) begin
            bcd_reg <= {bcd_adj[BCD_W-2:0], bin_reg[SW_W-1]};
            bin_reg <= {bin_reg[SW_W-2:0], 1'b0};
        end
    end

    // Update the stored digit codes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                codes_reg[i] <= '0;
            end
        end else if (cmd.load) begin
            unique case (s_buttons)
                BTN_BINARY: begin
                    for (int i = 0; i < DIGIT_COUNT; i++) begin
                        codes_reg[i] <= {4'd0, s_switches[DIGIT_COUNT-1-i]};
                    end
                end
                BTN_HEX: begin
                    codes_reg[0] <= BLANK_CODE;
                    codes_reg[1] <= BLANK_CODE;
                    codes_reg[2] <= BLANK_CODE;
                    codes_reg[3] <= BLANK_CODE;
                    codes_reg[4] <= {1'b0, s_switches[15:12]};
                    codes_reg[5] <= {1'b0, s_switches[11:8]};
                    codes_reg[6] <= {1'b0, s_switches[7:4]};
                    codes_reg[7] <= {1'b0, s_switches[3:0]};
                end
                default: begin
                end
            endcase
        end else if (cmd.dab_store) begin
            codes_reg[0] <= BLANK_CODE;
            codes_reg[1] <= BLANK_CODE;
            codes_reg[2] <= BLANK_CODE;
            codes_reg[3] <= {1'b0, bcd_reg[19:16]};
            codes_reg[4] <= {1'b0, bcd_reg[15:12]};
            codes_reg[5] <= {1'b0, bcd_reg[11:8]};
            codes_reg[6] <= {1'b0, bcd_reg[7:4]};
            codes_reg[7] <= {1'b0, bcd_reg[3:0]};
        end
    end

    // Drive the scan result for the current digit
    assign m_digit_select = ~(8'h80 >> cmd.scan_idx);
    assign m_segments     = seg_of(codes_reg[cmd.scan_idx]);
    assign m_last_digit   = (cmd.scan_idx == IDX_W'(DIGIT_COUNT - 1));

endmodule

@@ rtl/switch_value_seven_segment_display_top.sv @@
// Eight-digit multiplexed seven-segment driver for a switch value.
// Input channel (s_valid/s_ready): one item is a sample of s_buttons and
// s_switches. Button code 0x01 shows switch bits 7..0 in binary, 0x02 shows
// the value in hex on the right four digits, 0x10 in decimal on the right
// five digits; any other code keeps the digits already stored.
// Result channel (m_valid/m_ready): every item yields eight scan results,
// leftmost digit first, each with an active-low digit select and segment
// byte; m_last_digit marks the eighth.
// The first result is offered in the cycle after the item is taken, or in
// decimal mode once a double-dabble unit has taken one bit of the 16-bit
// value per cycle and a store state has written the digits.
// One item is in work at a time: s_ready is high only while no scan is
// pending. A stalled receiver holds the current digit on the result ports.
// Reset clears all digit codes to zero, so a scan then shows "00000000".
module switch_value_seven_segment_display_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_buttons,
    input  logic [15:0] s_switches,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_digit_select,
    output logic [7:0]  m_segments,
    output logic        m_last_digit
);
    import swseg_pkg::*;

    cmd_t    cmd;
    status_t status;

    swseg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    swseg_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_buttons      (s_buttons),
        .s_switches     (s_switches),
        .cmd            (cmd),
        .status         (status),
        .m_digit_select (m_digit_select),
        .m_segments     (m_segments),
        .m_last_digit   (m_last_digit)
    );

endmodule

@@ tb/switch_value_seven_segment_display_top_tb.sv @@
`timescale 1ns / 1ps

module switch_value_seven_segment_display_top_tb;

    import swseg_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_ITEMS   = 300;
    localparam int QUIET_ITEMS    = 60;
    localparam int LONG_HOLD      = 250;
    localparam int DRAIN_CYCLES   = 40;
    localparam int CYCLE_LIMIT    = 200000;

    // Active-low patterns for hex digits 0..F, then blank
    localparam logic [7:0] DIGIT_PATTERNS [0:16] = '{
        8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90,
        8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e, 8'hff
    };

    typedef struct {
        logic [7:0] digit_select;
        logic [7:0] segments;
        logic       last_digit;
    } scan_result_t;

    // Tracks the stored digit codes and the scan results still owed
    class scan_scoreboard;
        logic [4:0]   digit_codes [DIGIT_COUNT];
        scan_result_t scan_q [$];
        int           errors;

        function new();
            foreach (digit_codes[i]) digit_codes[i] = '0;
            errors = 0;
        endfunction

        function logic [7:0] pattern_of(logic [4:0] code);
            logic [7:0] pat;
            if (code > BLANK_CODE) begin
                pat = 8'hff;
            end else begin
                pat = DIGIT_PATTERNS[code];
            end
            return pat;
        endfunction

        // Update the digit codes for one item and queue its eight scan results
        function void note_sample(logic [4:0] buttons, logic [15:0] switches);
            int           value;
            scan_result_t res;
            value = switches;
            if (buttons == BTN_BINARY) begin
                for (int i = 0; i < DIGIT_COUNT; i++)
                    digit_codes[i] = {4'd0, switches[7 - i]};
            end else if (buttons == BTN_HEX) begin
                for (int i = 0; i < 4; i++) digit_codes[i] = BLANK_CODE;
                digit_codes[4] = {1'b0, switches[15:12]};
                digit_codes[5] = {1'b0, switches[11:8]};
                digit_codes[6] = {1'b0, switches[7:4]};
                digit_codes[7] = {1'b0, switches[3:0]};
            end else if (buttons == BTN_DECIMAL) begin
                for (int i = 0; i < 3; i++) digit_codes[i] = BLANK_CODE;
                digit_codes[3] = 5'(value / 10000);
                digit_codes[4] = 5'((value / 1000) % 10);
                digit_codes[5] = 5'((value / 100) % 10);
                digit_codes[6] = 5'((value / 10) % 10);
                digit_codes[7] = 5'(value % 10);
            end
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                res.digit_select = ~(8'h80 >> i);
                res.segments     = pattern_of(digit_codes[i]);
                res.last_digit   = (i == DIGIT_COUNT - 1);
                scan_q.push_back(res);
            end
        endfunction

        // Compare one accepted result with the oldest owed scan result
        function void check_scan(logic [7:0] digit_select, logic [7:0] segments,
                                 logic last_digit);
            scan_result_t exp_res;
            if (scan_q.size() == 0) begin
                $error("unexpected result: digit_select %h segments %h last_digit %b",
                       digit_select, segments, last_digit);
                errors++;
                return;
            end
            exp_res = scan_q.pop_front();
            if (digit_select !== exp_res.digit_select) begin
                $error("digit_select: expected %h, got %h",
                       exp_res.digit_select, digit_select);
                errors++;
            end
            if (segments !== exp_res.segments) begin
                $error("segments: expected %h, got %h", exp_res.segments, segments);
                errors++;
            end
            if (last_digit !== exp_res.last_digit) begin
                $error("last_digit: expected %b, got %b",
                       exp_res.last_digit, last_digit);
                errors++;
            end
        endfunction

        function int pending();
            return scan_q.size();
        endfunction
    endclass

    logic        aclk       = 1'b0;
    logic        aresetn    = 1'b0;
    logic        s_valid    = 1'b0;
    logic        s_ready;
    logic [4:0]  s_buttons  = '0;
    logic [15:0] s_switches = '0;
    logic        m_valid;
    logic        m_ready    = 1'b0;
    logic [7:0]  m_digit_select;
    logic [7:0]  m_segments;
    logic        m_last_digit;

    scan_scoreboard scan_sb;
    bit             quiet        = 1'b0;
    bit             hold_results = 1'b0;
    int             cycle_count  = 0;

    switch_value_seven_segment_display_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_buttons      (s_buttons),
        .s_switches     (s_switches),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_digit_select (m_digit_select),
        .m_segments     (m_segments),
        .m_last_digit   (m_last_digit)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Check every accepted result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            scan_sb.check_scan(m_digit_select, m_segments, m_last_digit);
    end

    // Drive m_ready: random stall bursts, one long hold on request
    initial begin
        int burst;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
                hold_results = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 11);
                m_ready <= 1'b0;
                repeat (burst - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one item, wait for it to be taken, then maybe idle for a burst
    task automatic offer_sample(input logic [4:0] buttons, input logic [15:0] switches);
        int gap;
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_buttons  <= buttons;
        s_switches <= switches;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        scan_sb.note_sample(buttons, switches);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // Mostly mode codes, sometimes any button combination
    function automatic logic [4:0] pick_buttons();
        int pick;
        logic [4:0] buttons;
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            buttons = BTN_BINARY;
        end else if (pick < 6) begin
            buttons = BTN_HEX;
        end else if (pick < 8) begin
            buttons = BTN_DECIMAL;
        end else begin
            buttons = 5'($urandom_range(0, 31));
        end
        return buttons;
    endfunction

    // Bias toward values at digit and range boundaries
    function automatic logic [15:0] pick_switches();
        logic [15:0] edges [8] = '{16'h0000, 16'hffff, 16'd9999, 16'd10000,
                                   16'd59999, 16'd60000, 16'd99, 16'd1000};
        logic [15:0] value;
        if ($urandom_range(0, 4) == 0) begin
            value = edges[$urandom_range(0, 7)];
        end else begin
            value = 16'($urandom);
        end
        return value;
    endfunction

    initial begin
        scan_sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset digits, each mode at its extremes, other codes
        offer_sample(5'h00, 16'h1234);
        offer_sample(BTN_BINARY, 16'h00ff);
        offer_sample(BTN_BINARY, 16'hff00);
        offer_sample(BTN_BINARY, 16'haa55);
        offer_sample(5'h03, 16'hffff);
        offer_sample(BTN_HEX, 16'h0000);
        offer_sample(BTN_HEX, 16'hffff);
        offer_sample(BTN_HEX, 16'h1234);
        offer_sample(BTN_HEX, 16'hcdef);
        offer_sample(5'h1f, 16'h0000);
        offer_sample(BTN_DECIMAL, 16'd0);
        offer_sample(BTN_DECIMAL, 16'd65535);
        offer_sample(BTN_DECIMAL, 16'd9999);
        offer_sample(BTN_DECIMAL, 16'd10000);
        offer_sample(BTN_DECIMAL, 16'd12345);
        offer_sample(5'h11, 16'h5555);
        offer_sample(5'h04, 16'haaaa);
        offer_sample(5'h08, 16'h0001);
        offer_sample(5'h12, 16'h8000);
        offer_sample(5'h00, 16'h0000);

        // Random items; long receiver hold early on, quiet tail at the end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 30) hold_results = 1'b1;
            if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            offer_sample(pick_buttons(), pick_switches());
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        // Drain owed results, then watch for stray ones
        while (scan_sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (scan_sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
